FILE: rtl/nearest_palette_color_assert.svh
// assertion helpers for the block that checks itself
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define NPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest palette color: check failed");

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define NPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest palette color: check failed");

`endif

FILE: rtl/npc_pkg.sv
package npc_pkg;

  localparam int unsigned CH_W     = 8;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned SQ_W     = 16;
  localparam int unsigned DIST_W   = 18;
  localparam int unsigned SIZE_W   = 9;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned PADDR_W  = 3;

  // number of slots an 8-bit entry index can reach
  localparam int unsigned ADDR_ENTRIES = 256;

  localparam logic [SIZE_W-1:0] PALETTE_SIZE_RST = SIZE_W'(1);
  localparam logic [DIST_W-1:0] MAX_DIST         = DIST_W'(195075);

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_PALETTE_SIZE = '0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef struct packed {
    op_e              opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  in_red;
    logic [CH_W-1:0]  in_green;
    logic [CH_W-1:0]  in_blue;
    logic [CH_W-1:0]  in_alpha;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [CH_W-1:0]   out_red;
    logic [CH_W-1:0]   out_green;
    logic [CH_W-1:0]   out_blue;
    logic [CH_W-1:0]   out_alpha;
    logic [DIST_W-1:0] best_distance;
  } out_beat_t;

  // squared channel differences of one palette entry, with its index and word
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic [SQ_W-1:0]   sq_r;
    logic [SQ_W-1:0]   sq_g;
    logic [SQ_W-1:0]   sq_b;
  } dist_t;

endpackage

FILE: rtl/npc_in_if.sv
interface npc_in_if;
  logic               valid;
  logic               ready;
  npc_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/npc_out_if.sv
interface npc_out_if;
  logic               valid;
  logic               ready;
  npc_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/npc_ram.sv
module npc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/npc_dist.sv
module npc_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [npc_pkg::IDX_W-1:0]     idx_i,
  input  logic [npc_pkg::WORD_W-1:0]    word_i,
  input  logic [npc_pkg::CH_W-1:0]      q_red_i,
  input  logic [npc_pkg::CH_W-1:0]      q_green_i,
  input  logic [npc_pkg::CH_W-1:0]      q_blue_i,
  output npc_pkg::dist_t                res_o
);

  logic [npc_pkg::CH_W-1:0] d_r, d_g, d_b;
  logic [npc_pkg::CH_W-1:0] e_r, e_g, e_b;
  logic                     valid_q;
  npc_pkg::dist_t           res_d, res_q;

  assign e_r = word_i[npc_pkg::CH_W-1:0];
  assign e_g = word_i[2*npc_pkg::CH_W-1:npc_pkg::CH_W];
  assign e_b = word_i[3*npc_pkg::CH_W-1:2*npc_pkg::CH_W];

  // absolute channel differences
  assign d_r = (q_red_i   >= e_r) ? (q_red_i   - e_r) : (e_r - q_red_i);
  assign d_g = (q_green_i >= e_g) ? (q_green_i - e_g) : (e_g - q_green_i);
  assign d_b = (q_blue_i  >= e_b) ? (q_blue_i  - e_b) : (e_b - q_blue_i);

  always_comb begin
    res_d.valid = valid_i;
    res_d.idx   = idx_i;
    res_d.word  = word_i;
    res_d.sq_r  = npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
    res_d.sq_g  = npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
    res_d.sq_b  = npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= res_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // payload from the data register, valid from the reset register
  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

endmodule

FILE: rtl/nearest_palette_color.sv
// nearest palette color search: a palette of PALETTE_DEPTH RGBA entries sits in
// one single-port-read RAM (red in bits 7..0, green 15..8, blue 23..16, alpha
// 31..24). A load beat writes one entry in the cycle it is accepted and gives no
// result; a load beat whose entry_index is not below PALETTE_DEPTH is dropped.
// A query beat scans entries 0 .. n-1, where n is palette_size (register 0,
// byte address 0) with zero read as one and values above min(PALETTE_DEPTH,
// 256) clamped to that. One RAM read and one distance (three squared channel
// differences summed, alpha left out) go through per cycle while the scan
// runs. A query holds the input from acceptance until its result is
// registered. The strictly-smaller compare keeps the lowest index on equal
// distances. Entries are undefined until loaded: a query must only scan
// entries written since reset. The result waits in an output register, so
// the next beat can be accepted while it is still unclaimed.
// palette_size should only be written while the block is idle.
module nearest_palette_color #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  npc_in_if.sink                          in_i,
  npc_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [npc_pkg::PADDR_W-1:0]     paddr,
  input  logic [npc_pkg::PDATA_W-1:0]     pwdata,
  output logic [npc_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  `include "nearest_palette_color_assert.svh"

  localparam int unsigned AW  = $clog2(PALETTE_DEPTH);
  // width that can carry both an 8-bit index and a RAM address
  localparam int unsigned IW  = (AW > npc_pkg::IDX_W) ? AW : npc_pkg::IDX_W;
  localparam int unsigned LIM = (PALETTE_DEPTH < npc_pkg::ADDR_ENTRIES) ?
                                PALETTE_DEPTH : npc_pkg::ADDR_ENTRIES;
  localparam logic [npc_pkg::SIZE_W-1:0] LIM_N = npc_pkg::SIZE_W'(LIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------- config
  logic [npc_pkg::SIZE_W-1:0] size_q;
  logic                       reg_hit;
  logic                       cfg_we;

  assign reg_hit = (paddr[npc_pkg::PADDR_W-1:2] == npc_pkg::REG_PALETTE_SIZE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? npc_pkg::PDATA_W'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= npc_pkg::PALETTE_SIZE_RST;
    end else if (cfg_we) begin
      size_q <= pwdata[npc_pkg::SIZE_W-1:0];
    end
  end

  // entries in use, zero read as one, clamped to what the store can hold
  logic [npc_pkg::SIZE_W-1:0] n_eff, n_m1;
  logic [npc_pkg::IDX_W-1:0]  last_q;

  always_comb begin
    n_eff = size_q;
    if (n_eff == '0) begin
      n_eff = npc_pkg::SIZE_W'(1);
    end
    if (n_eff > LIM_N) begin
      n_eff = LIM_N;
    end
  end
  assign n_m1 = n_eff - npc_pkg::SIZE_W'(1);

  // ------------------------------------------------------------ input side
  logic                  in_acc;
  logic                  is_query;
  logic                  ld_in_range;
  logic                  ram_we;
  logic [IW-1:0]         widx_ext;
  logic [npc_pkg::CH_W-1:0] qr_q, qg_q, qb_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_query    = (in_i.data.opcode == npc_pkg::OP_QUERY);
  assign ld_in_range = (32'(in_i.data.entry_index) < 32'(PALETTE_DEPTH));
  assign ram_we      = in_acc && (in_i.data.opcode == npc_pkg::OP_LOAD) && ld_in_range;
  assign widx_ext    = IW'(in_i.data.entry_index);

  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      qr_q   <= in_i.data.in_red;
      qg_q   <= in_i.data.in_green;
      qb_q   <= in_i.data.in_blue;
      last_q <= n_m1[npc_pkg::IDX_W-1:0];
    end
  end

  // ------------------------------------------------------------- sequencer
  logic [npc_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  logic [npc_pkg::IDX_W-1:0]  idx1_q;
  logic                       v1_q, v1_d;
  logic                       ram_re;
  logic [IW-1:0]              ridx_ext;
  logic [npc_pkg::WORD_W-1:0] ram_rdata;
  logic                       out_load;
  logic                       out_valid_q;
  npc_pkg::dist_t             dist_res;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    v1_d     = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        // one RAM read per cycle, the last address closes the scan
        v1_d  = 1'b1;
        cnt_d = cnt_q + npc_pkg::IDX_W'(1);
        if (cnt_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // pipeline empty means the best entry is final; it is loaded once the output register is free
        if (!v1_q && !dist_res.valid && (!out_valid_q || out_o.ready)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= v1_d;
    end
  end

  assign ram_re   = (state_q == ST_SCAN);
  assign ridx_ext = IW'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      idx1_q <= cnt_q;
    end
  end

  npc_ram #(
    .WIDTH (npc_pkg::WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_ext[AW-1:0]),
    .wdata_i ({in_i.data.in_alpha, in_i.data.in_blue,
               in_i.data.in_green, in_i.data.in_red}),
    .re_i    (ram_re),
    .raddr_i (ridx_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared distance unit: squares of the three channel differences
  npc_dist u_dist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v1_q),
    .idx_i     (idx1_q),
    .word_i    (ram_rdata),
    .q_red_i   (qr_q),
    .q_green_i (qg_q),
    .q_blue_i  (qb_q),
    .res_o     (dist_res)
  );

  // ------------------------------------------------------ sum and compare
  logic [npc_pkg::DIST_W-1:0] d_sum;
  logic [npc_pkg::DIST_W-1:0] best_d_q;
  logic [npc_pkg::IDX_W-1:0]  best_idx_q;
  logic [npc_pkg::WORD_W-1:0] best_word_q;
  logic                       take;

  assign d_sum = npc_pkg::DIST_W'(dist_res.sq_r) + npc_pkg::DIST_W'(dist_res.sq_g)
               + npc_pkg::DIST_W'(dist_res.sq_b);
  // entry zero seeds the search, later ones must be strictly closer
  assign take  = dist_res.valid && ((dist_res.idx == '0) || (d_sum < best_d_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_d_q    <= d_sum;
      best_idx_q  <= dist_res.idx;
      best_word_q <= dist_res.word;
    end
  end

  // --------------------------------------------------------- output register
  npc_pkg::out_beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.best_index    <= best_idx_q;
      out_q.out_red       <= best_word_q[npc_pkg::CH_W-1:0];
      out_q.out_green     <= best_word_q[2*npc_pkg::CH_W-1:npc_pkg::CH_W];
      out_q.out_blue      <= best_word_q[3*npc_pkg::CH_W-1:2*npc_pkg::CH_W];
      out_q.out_alpha     <= best_word_q[4*npc_pkg::CH_W-1:3*npc_pkg::CH_W];
      out_q.best_distance <= best_d_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // ------------------------------------------------------------- checks
  // a query always starts its scan at entry zero
  `NPC_ASSERT_NEXT(a_scan_start, in_acc && is_query, (state_q == ST_SCAN) && (cnt_q == '0))
  // the scan never reads past the last entry in use
  `NPC_ASSERT_NOW(a_scan_bound, state_q == ST_SCAN, cnt_q <= last_q)
  // a result only appears when a scan has drained
  `NPC_ASSERT_NOW(a_out_src, $rose(out_valid_q), $past(state_q == ST_DRAIN))
  // distance of three 8-bit channels stays in range
  `NPC_ASSERT_NOW(a_dist_range, out_valid_q, out_q.best_distance <= npc_pkg::MAX_DIST)

endmodule
